// ===== hw/rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int IN_W    = 16;   // input element, signed
    localparam int OUT_W   = 32;   // inverse element, signed
    localparam int N_ELEM  = 9;
    localparam int PROD_W  = 2 * IN_W;          // 16x16 product
    localparam int COF_W   = PROD_W + 1;        // cofactor, difference of two products
    localparam int DET_W   = COF_W + IN_W;      // determinant, |det| < 3 * 2^46
    localparam int DEN_W   = DET_W - 1;         // divisor magnitude
    localparam int MAG_W   = PROD_W;            // cofactor magnitude, <= 2^31
    localparam int QUO_W   = OUT_W;             // quotient bits developed
    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 16;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== hw/rtl/mi3_adjugate.sv =====
`timescale 1ns / 1ps

// Cofactors (rows b x c, c x a, a x b) and determinant, four register stages.
module mi3_adjugate
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [mi3_pkg::IN_W-1:0]      m [mi3_pkg::N_ELEM],
    output logic                                 out_valid,
    output logic signed [mi3_pkg::COF_W-1:0]     cof [mi3_pkg::N_ELEM],
    output logic signed [mi3_pkg::DET_W-1:0]     det
);

    localparam int COF_W = mi3_pkg::COF_W;

    logic                                 vld_reg [4];
    logic signed [mi3_pkg::PROD_W-1:0]    pa_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0]    pb_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0]    pa_next [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0]    pb_next [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::COF_W-1:0]     cof2_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::COF_W-1:0]     cof3_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::COF_W-1:0]     cof4_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::IN_W-1:0]      c1_reg [3];
    logic signed [mi3_pkg::IN_W-1:0]      c2_reg [3];
    logic signed [mi3_pkg::DET_W-1:0]     dp_reg [3];
    logic signed [mi3_pkg::DET_W-1:0]     det_reg;

    // component k of col(U) x col(V): u[k+1]v[k+2] - u[k+2]v[k+1]
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar k = 0; k < 3; k++)
        begin : g_comp
            localparam int U  = (r + 1) % 3;
            localparam int V  = (r + 2) % 3;
            localparam int KA = (k + 1) % 3;
            localparam int KB = (k + 2) % 3;
            assign pa_next[r*3+k] = m[KA*3+U] * m[KB*3+V];
            assign pb_next[r*3+k] = m[KB*3+U] * m[KA*3+V];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < mi3_pkg::N_ELEM; i++)
            begin
                pa_reg[i]   <= pa_next[i];
                pb_reg[i]   <= pb_next[i];
                cof2_reg[i] <= COF_W'(pa_reg[i]) - COF_W'(pb_reg[i]);
                cof3_reg[i] <= cof2_reg[i];
                cof4_reg[i] <= cof3_reg[i];
            end
            for (int k = 0; k < 3; k++)
            begin
                c1_reg[k] <= m[k*3+2];
                c2_reg[k] <= c1_reg[k];
                dp_reg[k] <= cof2_reg[6+k] * c2_reg[k];
            end
            det_reg <= dp_reg[0] + dp_reg[1] + dp_reg[2];
        end
    end

    assign out_valid = vld_reg[3];
    assign cof       = cof4_reg;
    assign det       = det_reg;

endmodule

// ===== hw/rtl/mi3_divider.sv =====
`timescale 1ns / 1ps

// Nine restoring dividers sharing one divisor, one quotient bit per stage.
module mi3_divider
#(
    parameter int IN_FRAC_BITS  = mi3_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = mi3_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [mi3_pkg::COF_W-1:0]     cof [mi3_pkg::N_ELEM],
    input  logic signed [mi3_pkg::DET_W-1:0]     det,
    output logic                                 out_valid,
    output logic        [mi3_pkg::OUT_W-1:0]     inv [mi3_pkg::N_ELEM],
    output logic                                 singular,
    output logic                                 overflow
);

    localparam int NL    = mi3_pkg::N_ELEM;
    localparam int QW    = mi3_pkg::QUO_W;
    localparam int DW    = mi3_pkg::DEN_W;
    localparam int MW    = mi3_pkg::MAG_W;
    localparam int SH    = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int NW    = MW + SH;                 // shifted numerator
    localparam int TW    = NW - QW;                 // numerator above the quotient bits
    localparam int CW    = (TW > DW) ? TW : DW;
    localparam int NS    = QW + 1;                  // step stage count incl. start

    // stage A
    logic                 a_vld_reg;
    logic                 a_sing_reg;
    logic [DW-1:0]        a_dm_reg;
    logic [MW-1:0]        a_mag_reg [NL];
    logic                 a_neg_reg [NL];
    logic [mi3_pkg::DET_W-1:0] det_abs;
    logic [mi3_pkg::COF_W-1:0] cof_abs [NL];

    // step stages, index 0 is the start stage
    logic                 s_vld_reg  [NS];
    logic                 s_sing_reg [NS];
    logic [DW-1:0]        s_dm_reg   [NS];
    logic [MW-1:0]        s_mag_reg  [NL][NS];
    logic                 s_neg_reg  [NL][NS];
    logic                 s_big_reg  [NL][NS];
    logic [DW-1:0]        s_rem_reg  [NL][NS];
    logic [QW-1:0]        s_q_reg    [NL][NS];
    logic [DW-1:0]        s_rem_next [NL][NS];
    logic [QW-1:0]        s_q_next   [NL][NS];
    logic                 b_big_next [NL];
    logic [DW-1:0]        b_rem_next [NL];

    // output stage
    logic                 o_vld_reg;
    logic                 o_sing_reg;
    logic                 o_ovf_reg;
    logic [mi3_pkg::OUT_W-1:0] o_inv_reg [NL];
    logic [mi3_pkg::OUT_W-1:0] o_inv_next [NL];
    logic                 o_sat_next [NL];
    logic                 o_ovf_next;

    always_comb
    begin
        det_abs = det[mi3_pkg::DET_W-1] ? -det : det;
        for (int l = 0; l < NL; l++)
        begin
            cof_abs[l] = cof[l][mi3_pkg::COF_W-1] ? -cof[l] : cof[l];
        end
    end

    // start stage: anything at or above 2^QW in the quotient saturates
    always_comb
    begin
        logic [NW-1:0] num;
        logic [CW-1:0] top;
        for (int l = 0; l < NL; l++)
        begin
            num           = {a_mag_reg[l], {SH{1'b0}}};
            top           = CW'(num[NW-1:QW]);
            b_big_next[l] = top >= CW'(a_dm_reg);
            b_rem_next[l] = top[DW-1:0];
        end
    end

    always_comb
    begin
        logic [NW-1:0] num;
        logic [DW:0]   t;
        for (int l = 0; l < NL; l++)
        begin
            for (int s = 0; s < NS - 1; s++)
            begin
                num = {s_mag_reg[l][s], {SH{1'b0}}};
                t   = {s_rem_reg[l][s], num[QW-1-s]};
                if (t >= {1'b0, s_dm_reg[s]})
                begin
                    t             = t - {1'b0, s_dm_reg[s]};
                    s_q_next[l][s] = {s_q_reg[l][s][QW-2:0], 1'b1};
                end
                else
                begin
                    s_q_next[l][s] = {s_q_reg[l][s][QW-2:0], 1'b0};
                end
                s_rem_next[l][s] = t[DW-1:0];
            end
            s_q_next[l][NS-1]   = s_q_reg[l][NS-1];
            s_rem_next[l][NS-1] = s_rem_reg[l][NS-1];
        end
    end

    always_comb
    begin
        logic [QW-1:0] q;
        logic          neg;
        o_ovf_next = 1'b0;
        for (int l = 0; l < NL; l++)
        begin
            q   = s_q_reg[l][NS-1];
            neg = s_neg_reg[l][NS-1];
            o_sat_next[l] = s_big_reg[l][NS-1] ||
                            (neg ? (q[QW-1] && (|q[QW-2:0])) : q[QW-1]);
            if (s_sing_reg[NS-1])
            begin
                o_inv_next[l] = '0;
            end
            else if (o_sat_next[l])
            begin
                o_inv_next[l] = neg ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
            end
            else
            begin
                o_inv_next[l] = neg ? -q : q;
            end
            o_ovf_next = o_ovf_next | (o_sat_next[l] & ~s_sing_reg[NS-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            for (int s = 0; s < NS; s++)
            begin
                s_vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            a_vld_reg    <= in_valid;
            s_vld_reg[0] <= a_vld_reg;
            for (int s = 1; s < NS; s++)
            begin
                s_vld_reg[s] <= s_vld_reg[s-1];
            end
            o_vld_reg <= s_vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sing_reg    <= (det == '0);
            a_dm_reg      <= det_abs[DW-1:0];
            s_sing_reg[0] <= a_sing_reg;
            s_dm_reg[0]   <= a_dm_reg;
            for (int s = 1; s < NS; s++)
            begin
                s_sing_reg[s] <= s_sing_reg[s-1];
                s_dm_reg[s]   <= s_dm_reg[s-1];
            end
            for (int l = 0; l < NL; l++)
            begin
                a_mag_reg[l]    <= cof_abs[l][MW-1:0];
                a_neg_reg[l]    <= cof[l][mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
                s_mag_reg[l][0] <= a_mag_reg[l];
                s_neg_reg[l][0] <= a_neg_reg[l];
                s_big_reg[l][0] <= b_big_next[l];
                s_rem_reg[l][0] <= b_rem_next[l];
                s_q_reg[l][0]   <= '0;
                for (int s = 1; s < NS; s++)
                begin
                    s_mag_reg[l][s] <= s_mag_reg[l][s-1];
                    s_neg_reg[l][s] <= s_neg_reg[l][s-1];
                    s_big_reg[l][s] <= s_big_reg[l][s-1];
                    s_rem_reg[l][s] <= s_rem_next[l][s-1];
                    s_q_reg[l][s]   <= s_q_next[l][s-1];
                end
                o_inv_reg[l] <= o_inv_next[l];
            end
            o_sing_reg <= s_sing_reg[NS-1];
            o_ovf_reg  <= o_ovf_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign inv       = o_inv_reg;
    assign singular  = o_sing_reg;
    assign overflow  = o_ovf_reg;

endmodule

// ===== hw/rtl/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate. One request per cycle is taken while the
// result side keeps up. Four stages form the cofactors and the exact determinant,
// then each of the nine elements goes through a restoring divider that yields
// one quotient bit per stage (32 stages plus the setup stages A and start and a
// final saturation stage). The whole pipeline holds while a result waits under
// out_stall, so in_stall follows out_valid && out_stall. Quotients round toward
// zero; a zero determinant gives all-zero elements with singular set, and
// elements beyond the 32-bit range saturate with overflow set.
module matrix_inverse_3x3
#(
    parameter int IN_FRAC_BITS  = mi3_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = mi3_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r0c0,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r0c1,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r0c2,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r1c0,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r1c1,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r1c2,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r2c0,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r2c1,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem_r2c2,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r0c0,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r0c1,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r0c2,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r1c0,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r1c1,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r1c2,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r2c0,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r2c1,
    output logic signed [mi3_pkg::OUT_W-1:0]  inv_r2c2,
    output logic                              singular,
    output logic                              overflow
);

    logic                              en;
    logic signed [mi3_pkg::IN_W-1:0]   m [mi3_pkg::N_ELEM];
    logic                              adj_valid;
    logic signed [mi3_pkg::COF_W-1:0]  cof [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::DET_W-1:0]  det;
    logic        [mi3_pkg::OUT_W-1:0]  inv [mi3_pkg::N_ELEM];

    assign in_stall = out_valid & out_stall;
    assign en       = ~in_stall;

    assign m[0] = elem_r0c0;
    assign m[1] = elem_r0c1;
    assign m[2] = elem_r0c2;
    assign m[3] = elem_r1c0;
    assign m[4] = elem_r1c1;
    assign m[5] = elem_r1c2;
    assign m[6] = elem_r2c0;
    assign m[7] = elem_r2c1;
    assign m[8] = elem_r2c2;

    mi3_adjugate u_adj
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .m         (m),
        .out_valid (adj_valid),
        .cof       (cof),
        .det       (det)
    );

    mi3_divider
    #(
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    )
    u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adj_valid),
        .cof       (cof),
        .det       (det),
        .out_valid (out_valid),
        .inv       (inv),
        .singular  (singular),
        .overflow  (overflow)
    );

    assign inv_r0c0 = inv[0];
    assign inv_r0c1 = inv[1];
    assign inv_r0c2 = inv[2];
    assign inv_r1c0 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r1c2 = inv[5];
    assign inv_r2c0 = inv[6];
    assign inv_r2c1 = inv[7];
    assign inv_r2c2 = inv[8];

endmodule

// ===== hw/rtl/mi3_checker.sv =====
`timescale 1ns / 1ps

module mi3_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [mi3_pkg::OUT_W-1:0]  inv_r0c0,
    input logic signed [mi3_pkg::OUT_W-1:0]  inv_r1c1,
    input logic signed [mi3_pkg::OUT_W-1:0]  inv_r2c2,
    input logic                              singular,
    input logic                              overflow
);

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inv_r0c0) && $stable(singular))
        else $error("stalled result changed");

    // input side stalls exactly when a finished result is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not track output stall");

    // singular result carries zero diagonal elements and no overflow
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !overflow && inv_r0c0 == '0 && inv_r1c1 == '0
                                   && inv_r2c2 == '0)
        else $error("singular result not cleared");

    // no result right after reset release
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid at reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .inv_r0c0  (inv_r0c0),
    .inv_r1c1  (inv_r1c1),
    .inv_r2c2  (inv_r2c2),
    .singular  (singular),
    .overflow  (overflow)
);

// ===== tb/matrix_inverse_3x3_checker.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [mi3_pkg::IN_W-1:0]   elem [9],
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [mi3_pkg::OUT_W-1:0]  inv [9],
    input  logic                              singular,
    input  logic                              overflow,
    output int                                errors,
    output int                                pending
);

    localparam int SHIFT = mi3_pkg::IN_FRAC_BITS_DEF + mi3_pkg::OUT_FRAC_BITS_DEF;

    typedef struct {
        logic [mi3_pkg::OUT_W-1:0] el [9];
        logic                      sing;
        logic                      ovf;
    } inverse_t;

    inverse_t inverse_q [$];

    // truncating quotient of num * 2^SHIFT / den, saturated to 32 bits
    function automatic logic [mi3_pkg::OUT_W-1:0] scaled_quotient(longint num, longint den,
                                                                  inout logic ovf);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 128'(num) <<< SHIFT;
        q = n / 128'(den);
        if (q > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return mi3_pkg::SAT_POS;
        end
        if (q < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return mi3_pkg::SAT_NEG;
        end
        return q[mi3_pkg::OUT_W-1:0];
    endfunction

    function automatic inverse_t invert(logic signed [mi3_pkg::IN_W-1:0] e [9]);
        longint m [3][3];
        longint cof [3][3];
        longint det;
        inverse_t res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = e[r*3+c];
        // row r of the adjugate = column (r+1) x column (r+2)
        for (int r = 0; r < 3; r++)
        begin
            int p;
            int s;
            p = (r + 1) % 3;
            s = (r + 2) % 3;
            cof[r][0] = m[1][p] * m[2][s] - m[2][p] * m[1][s];
            cof[r][1] = m[2][p] * m[0][s] - m[0][p] * m[2][s];
            cof[r][2] = m[0][p] * m[1][s] - m[1][p] * m[0][s];
        end
        det = cof[2][0] * m[0][2] + cof[2][1] * m[1][2] + cof[2][2] * m[2][2];
        res.ovf = 1'b0;
        res.sing = (det == 0);
        for (int i = 0; i < 9; i++)
            res.el[i] = res.sing ? '0 : scaled_quotient(cof[i/3][i%3], det, res.ovf);
        return res;
    endfunction

    assign pending = inverse_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            inverse_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result with no request pending");
                end
                else
                begin
                    inverse_t exp_r;
                    logic bad;
                    exp_r = inverse_q.pop_front();
                    bad = (singular !== exp_r.sing) || (overflow !== exp_r.ovf);
                    for (int i = 0; i < 9; i++)
                        if (inv[i] !== exp_r.el[i])
                            bad = 1'b1;
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("ERROR: inverse mismatch sing %0b/%0b ovf %0b/%0b",
                                     exp_r.sing, singular, exp_r.ovf, overflow);
                            for (int i = 0; i < 9; i++)
                                $display("  el%0d exp %h got %h", i, exp_r.el[i], inv[i]);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                inverse_q.push_back(invert(elem));
        end
    end

endmodule

// ===== tb/matrix_inverse_3x3_tb.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic signed [mi3_pkg::IN_W-1:0] elem [9] = '{default: '0};
    logic signed [mi3_pkg::OUT_W-1:0] inv [9];
    logic singular;
    logic overflow;
    int errors;
    int pending;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    matrix_inverse_3x3 uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .elem_r0c0(elem[0]), .elem_r0c1(elem[1]), .elem_r0c2(elem[2]),
        .elem_r1c0(elem[3]), .elem_r1c1(elem[4]), .elem_r1c2(elem[5]),
        .elem_r2c0(elem[6]), .elem_r2c1(elem[7]), .elem_r2c2(elem[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv_r0c0(inv[0]), .inv_r0c1(inv[1]), .inv_r0c2(inv[2]),
        .inv_r1c0(inv[3]), .inv_r1c1(inv[4]), .inv_r1c2(inv[5]),
        .inv_r2c0(inv[6]), .inv_r2c1(inv[7]), .inv_r2c2(inv[8]),
        .singular(singular), .overflow(overflow)
    );

    matrix_inverse_3x3_checker chk
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .elem(elem), .out_valid(out_valid), .out_stall(out_stall), .inv(inv),
        .singular(singular), .overflow(overflow), .errors(errors), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
    endfunction

    function automatic logic signed [mi3_pkg::IN_W-1:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
        endcase
    endfunction

    // random stall pattern, drawn anew each cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 299) < 60)
                out_stall <= 1'b0;
            else
                out_stall <= (gap_len() > 0);
        end
    end

    task automatic send(logic signed [mi3_pkg::IN_W-1:0] m [9]);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
            elem[i] <= m[i];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic signed [mi3_pkg::IN_W-1:0] m [9];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, zero, extremes, singular rows, tiny determinant, scaled identity, random
        for (int t = 0; t < 20; t++)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = '0;
            case (t)
                0: begin m[0] = 16'sd4096; m[4] = 16'sd4096; m[8] = 16'sd4096; end
                1: ;
                2: for (int i = 0; i < 9; i++) m[i] = 16'sh7FFF;
                3: for (int i = 0; i < 9; i++) m[i] = 16'sh8000;
                4: begin m[0] = 16'sh8000; m[4] = 16'sh8000; m[8] = 16'sh8000; end
                5: begin m[0] = 16'sh7FFF; m[4] = 16'sh7FFF; m[8] = 16'sh7FFF; end
                6: begin m[0] = 16'sd1; m[4] = 16'sd1; m[8] = 16'sd1; end
                7: begin m[0] = -16'sd1; m[4] = 16'sd1; m[8] = 16'sd1; end
                8: begin
                    m[0] = 16'sd1; m[4] = 16'sd4096; m[8] = 16'sd4096; m[1] = 16'sh7FFF;
                end
                9: begin
                    m[0] = 16'sd2; m[1] = 16'sd1; m[3] = 16'sd4; m[4] = 16'sd2;
                    m[8] = 16'sd1;
                end
                10: begin m[1] = 16'sd4096; m[5] = 16'sd4096; m[6] = 16'sd4096; end
                11: begin m[0] = 16'sh8000; m[4] = 16'sd1; m[8] = 16'sd1; end
                12: begin m[0] = -16'sd4096; m[4] = -16'sd4096; m[8] = -16'sd4096; end
                13: begin m[0] = 16'sd8; m[4] = 16'sd8; m[8] = 16'sh8000; end
                default: for (int i = 0; i < 9; i++) m[i] = rand_elem(t % 4);
            endcase
            send(m);
        end
        drain();

        for (int n = 0; n < 750; n++)
        begin
            int mode;
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                m[i] = rand_elem(mode);
            // force some dependent rows to hit singular matrices
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++)
                    m[6+i] = m[i];
            send(m);
            if (n == 375)
                drain();
        end
        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_adjugate.sv
hw/rtl/mi3_divider.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_checker.sv
tb/matrix_inverse_3x3_checker.sv
tb/matrix_inverse_3x3_tb.sv
